// ----- sv/bti_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear table interpolation package
// Shared types, codes and default sizes for the interpolation unit.
// ----------------------------------------------------------------------------
package bti_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_ROWS   = 16;
    localparam int DEF_MAX_COLS   = 16;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed widths of the word fields.
    localparam int WORD_W     = 32;
    localparam int MAG_W      = WORD_W + 1;
    localparam int CFG_W      = 5;
    localparam int CHUNK_BITS = 16;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_ROW_BRK = 2'd0,
        OP_COL_BRK = 2'd1,
        OP_GRID    = 2'd2,
        OP_QUERY   = 2'd3
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSIDE = 2'd0,
        ST_EXTRAP = 2'd1,
        ST_DEGEN  = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Selects for the shared linear step.
    localparam logic [1:0] LERP_ZL  = 2'd0;
    localparam logic [1:0] LERP_ZU  = 2'd1;
    localparam logic [1:0] LERP_ROW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       srch_cmp;
        logic       brk_lo;
        logic       cap_lo;
        logic       cap_hi;
        logic       prep;
        logic       grid_rd;
        logic [1:0] grid_idx;
        logic       div_start;
        logic       lerp_start;
        logic [1:0] lerp_sel;
        logic       lerp_cap;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic srch_done;
        logic div_done;
        logic lerp_done;
    } t_stat;

endpackage
`default_nettype wire

// ----- sv/bti_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- sv/bti_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module bti_div #(
    parameter int NW = 49,
    parameter int DW = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic      [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_num[NW-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // Bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // One trial subtraction per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_num  <= r_num << 1;
            r_quot <= {r_quot[NW-2:0], fits};
            if (fits) begin
                r_rem <= DW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DW-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ----- sv/bti_lerp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linear step unit
// Computes a + sign * (|m| * |b - a| >> FRAC), with the product built from
// chunks of the fraction, then saturates to the value width.
// ----------------------------------------------------------------------------
module bti_lerp #(
    parameter int VW = 32,
    parameter int MW = 49,
    parameter int FB = 16,
    parameter int VB = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [VW-1:0] i_a,
    input  wire logic signed [VW-1:0] i_b,
    input  wire logic        [MW-1:0] i_m_mag,
    input  wire logic                 i_m_neg,
    output logic                      o_busy,
    output logic signed      [VW-1:0] o_value
);
    import bti_pkg::*;

    localparam int DW  = VW + 1;
    localparam int CH  = CHUNK_BITS;
    localparam int NCH = (MW + CH - 1) / CH;
    localparam int MP  = NCH * CH;
    localparam int PW  = MP + DW;
    localparam int SW  = VW + 2;
    localparam int CW  = $clog2(NCH + 1);

    localparam logic [PW-1:0] LIM_P = PW'(1) << VB;
    localparam logic [VB:0]   LIM_M = (VB + 1)'(1) << VB;
    localparam logic signed [SW-1:0] SAT_HI = {{(SW - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW - VB + 1){1'b1}}, {(VB - 1){1'b0}}};

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_SCALE, L_SUM} t_lstate;

    t_lstate               r_state;
    logic [CW-1:0]         r_cnt;
    logic signed [VW-1:0]  r_a;
    logic [DW-1:0]         r_dmag;
    logic                  r_neg;
    logic [MP-1:0]         r_m;
    logic [PW-1:0]         r_acc;
    logic [VB:0]           r_mag;
    logic signed [VW-1:0]  r_val;

    logic signed [DW-1:0]  diff;
    logic [CH+DW-1:0]      prod;
    logic [PW-1:0]         p_sh;
    logic signed [SW-1:0]  mag_s;
    logic signed [SW-1:0]  sum;

    assign diff  = DW'(i_b) - DW'(i_a);
    assign prod  = {{DW{1'b0}}, r_m[MP-1 -: CH]} * {{CH{1'b0}}, r_dmag};
    assign p_sh  = r_acc >> FB;
    assign mag_s = $signed({{(SW - VB - 1){1'b0}}, r_mag});
    assign sum   = r_neg ? (SW'(r_a) - mag_s) : (SW'(r_a) + mag_s);

    // Sequencing of multiply, scale and sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_MUL;
                        r_cnt   <= CW'(NCH);
                    end
                end
                L_MUL: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= L_SCALE;
                    end
                end
                L_SCALE: r_state <= L_SUM;
                L_SUM:   r_state <= L_IDLE;
                default: r_state <= L_IDLE;
            endcase
        end
    end

    // Arithmetic registers.
    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_a    <= i_a;
            r_dmag <= diff[DW-1] ? DW'(-diff) : DW'(diff);
            r_neg  <= i_m_neg ^ diff[DW-1];
            r_m    <= MP'(i_m_mag);
            r_acc  <= '0;
        end
        if (r_state == L_MUL) begin
            r_acc <= (r_acc << CH) + PW'(prod);
            r_m   <= r_m << CH;
        end
        if (r_state == L_SCALE) begin
            r_mag <= (p_sh > LIM_P) ? LIM_M : p_sh[VB:0];
        end
        if (r_state == L_SUM) begin
            if (sum > SAT_HI) begin
                r_val <= SAT_HI[VW-1:0];
            end else if (sum < SAT_LO) begin
                r_val <= SAT_LO[VW-1:0];
            end else begin
                r_val <= sum[VW-1:0];
            end
        end
    end

    assign o_busy  = (r_state != L_IDLE);
    assign o_value = r_val;

endmodule
`default_nettype wire

// ----- sv/bti_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interpolation datapath
// Breakpoint and grid stores, segment search, fraction dividers, the shared
// linear step unit and the result register.
// ----------------------------------------------------------------------------
module bti_datapath #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bti_pkg::t_cmd                  i_cmd,
    output bti_pkg::t_stat                      o_stat,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_index,
    input  wire logic [bti_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire bti_pkg::t_opcode               i_opcode,
    input  wire logic [3:0]                     i_row_index,
    input  wire logic [3:0]                     i_col_index,
    input  wire logic signed [bti_pkg::WORD_W-1:0] i_write_value,
    input  wire logic signed [bti_pkg::WORD_W-1:0] i_query_row,
    input  wire logic signed [bti_pkg::WORD_W-1:0] i_query_col,
    output logic [bti_pkg::WORD_W-1:0]          o_result,
    output bti_pkg::t_status                    o_status
);
    import bti_pkg::*;

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int GD  = MAX_ROWS * MAX_COLS;
    localparam int GAW = $clog2(GD);
    localparam int VW  = (VALUE_BITS > WORD_W) ? VALUE_BITS : WORD_W;
    localparam int MW  = MAG_W + FRAC_BITS;

    typedef struct packed {
        logic [MAG_W-1:0] an;
        logic [MAG_W-1:0] ad;
        logic             neg;
        logic             deg;
        logic             ext;
    } t_frac;

    // Segment numerator/denominator magnitudes and flags.
    function automatic t_frac frac_prep(input logic signed [WORD_W-1:0] t,
                                        input logic signed [WORD_W-1:0] lo,
                                        input logic signed [WORD_W-1:0] hi);
        logic signed [MAG_W-1:0] num;
        logic signed [MAG_W-1:0] den;
        t_frac f;
        num   = MAG_W'(t) - MAG_W'(lo);
        den   = MAG_W'(hi) - MAG_W'(lo);
        f.an  = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
        f.ad  = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);
        f.deg = (den == '0);
        f.neg = (num != '0) && (num[MAG_W-1] != den[MAG_W-1]);
        f.ext = !f.deg && (f.neg || (f.an > f.ad));
        return f;
    endfunction

    // Last usable index for a count register.
    function automatic int clamp_last(input logic [CFG_W-1:0] v, input int mx);
        int n;
        n = int'(v);
        if (n < 2) begin
            n = 2;
        end
        if (n > mx) begin
            n = mx;
        end
        return n - 1;
    endfunction

    logic [CFG_W-1:0]          r_rows_cfg;
    logic [CFG_W-1:0]          r_cols_cfg;
    logic signed [WORD_W-1:0]  r_qr;
    logic signed [WORD_W-1:0]  r_qc;
    logic [RIW-1:0]            r_ru;
    logic [CIW-1:0]            r_cu;
    logic [RIW-1:0]            r_rlast;
    logic [CIW-1:0]            r_clast;
    logic                      r_rdone;
    logic                      r_cdone;
    logic signed [WORD_W-1:0]  r_rlo;
    logic signed [WORD_W-1:0]  r_rhi;
    logic signed [WORD_W-1:0]  r_clo;
    logic signed [WORD_W-1:0]  r_chi;
    t_frac                     r_rf;
    t_frac                     r_cf;
    logic                      r_grd_d;
    logic [1:0]                r_gidx_d;
    logic signed [VW-1:0]      r_g [4];
    logic signed [VW-1:0]      r_zl;
    logic signed [VW-1:0]      r_zu;
    logic [WORD_W-1:0]         r_result;
    t_status                   r_status;

    logic                      row_we;
    logic                      col_we;
    logic                      grid_we;
    logic [RIW-1:0]            row_raddr;
    logic [CIW-1:0]            col_raddr;
    logic [GAW-1:0]            grid_waddr;
    logic [GAW-1:0]            grid_raddr;
    logic [RIW-1:0]            g_row;
    logic [CIW-1:0]            g_col;
    logic [WORD_W-1:0]         row_rdata;
    logic [WORD_W-1:0]         col_rdata;
    logic [WORD_W-1:0]         grid_rdata;
    logic                      rdiv_busy;
    logic                      cdiv_busy;
    logic [MW-1:0]             rq;
    logic [MW-1:0]             cq;
    logic                      lerp_busy;
    logic signed [VW-1:0]      lerp_val;
    logic signed [VW-1:0]      l_a;
    logic signed [VW-1:0]      l_b;
    logic [MW-1:0]             l_m;
    logic                      l_neg;
    logic                      is_query;

    // Store writes from write words.
    assign row_we  = i_cmd.accept && (i_opcode == OP_ROW_BRK)
                     && (int'(i_row_index) < MAX_ROWS);
    assign col_we  = i_cmd.accept && (i_opcode == OP_COL_BRK)
                     && (int'(i_col_index) < MAX_COLS);
    assign grid_we = i_cmd.accept && (i_opcode == OP_GRID)
                     && (int'(i_row_index) < MAX_ROWS) && (int'(i_col_index) < MAX_COLS);
    assign grid_waddr = GAW'(i_row_index) * GAW'(MAX_COLS) + GAW'(i_col_index);
    assign is_query   = i_cmd.accept && (i_opcode == OP_QUERY);

    // Read addresses: the search point, or the lower end of the segment.
    assign row_raddr  = i_cmd.brk_lo ? (r_ru - RIW'(1)) : r_ru;
    assign col_raddr  = i_cmd.brk_lo ? (r_cu - CIW'(1)) : r_cu;
    assign g_row      = i_cmd.grid_idx[1] ? r_ru : (r_ru - RIW'(1));
    assign g_col      = i_cmd.grid_idx[0] ? r_cu : (r_cu - CIW'(1));
    assign grid_raddr = GAW'(g_row) * GAW'(MAX_COLS) + GAW'(g_col);

    bti_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (RIW'(i_row_index)),
        .i_wdata (i_write_value),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    bti_ram #(.WIDTH(WORD_W), .DEPTH(MAX_COLS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (CIW'(i_col_index)),
        .i_wdata (i_write_value),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    bti_ram #(.WIDTH(WORD_W), .DEPTH(GD)) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (i_write_value),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    // Configuration registers and search control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= CFG_W'(16);
            r_cols_cfg <= CFG_W'(16);
            r_rdone    <= 1'b0;
            r_cdone    <= 1'b0;
            r_grd_d    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data;
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                    default:  r_rows_cfg <= r_rows_cfg;
                endcase
            end
            r_grd_d <= i_cmd.grid_rd;
            if (is_query) begin
                r_rdone <= 1'b0;
                r_cdone <= 1'b0;
            end else if (i_cmd.srch_cmp) begin
                if (!r_rdone && (($signed(row_rdata) >= r_qr) || (r_ru == r_rlast))) begin
                    r_rdone <= 1'b1;
                end
                if (!r_cdone && (($signed(col_rdata) >= r_qc) || (r_cu == r_clast))) begin
                    r_cdone <= 1'b1;
                end
            end
        end
    end

    // Query payload, segment walk and captured operands.
    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_qr    <= i_query_row;
            r_qc    <= i_query_col;
            r_ru    <= RIW'(1);
            r_cu    <= CIW'(1);
            r_rlast <= RIW'(clamp_last(r_rows_cfg, MAX_ROWS));
            r_clast <= CIW'(clamp_last(r_cols_cfg, MAX_COLS));
        end else if (i_cmd.srch_cmp) begin
            if (!r_rdone && !(($signed(row_rdata) >= r_qr) || (r_ru == r_rlast))) begin
                r_ru <= r_ru + RIW'(1);
            end
            if (!r_cdone && !(($signed(col_rdata) >= r_qc) || (r_cu == r_clast))) begin
                r_cu <= r_cu + CIW'(1);
            end
        end
        if (i_cmd.cap_lo) begin
            r_rlo <= $signed(row_rdata);
            r_clo <= $signed(col_rdata);
        end
        if (i_cmd.cap_hi) begin
            r_rhi <= $signed(row_rdata);
            r_chi <= $signed(col_rdata);
        end
        if (i_cmd.prep) begin
            r_rf <= frac_prep(r_qr, r_rlo, r_rhi);
            r_cf <= frac_prep(r_qc, r_clo, r_chi);
        end
        if (r_grd_d) begin
            r_g[r_gidx_d] <= VW'($signed(grid_rdata));
        end
        r_gidx_d <= i_cmd.grid_idx;
        if (i_cmd.lerp_cap) begin
            unique case (i_cmd.lerp_sel)
                LERP_ZL: r_zl <= lerp_val;
                LERP_ZU: r_zu <= lerp_val;
                default: r_zl <= r_zl;
            endcase
        end
        if (i_cmd.out_load) begin
            r_result <= lerp_val[WORD_W-1:0];
            if (r_rf.deg || r_cf.deg) begin
                r_status <= ST_DEGEN;
            end else if (r_rf.ext || r_cf.ext) begin
                r_status <= ST_EXTRAP;
            end else begin
                r_status <= ST_INSIDE;
            end
        end
    end

    // Fraction dividers, one per axis.
    bti_div #(.NW(MW), .DW(MAG_W)) u_row_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_rf.an, {FRAC_BITS{1'b0}}}),
        .i_den   (r_rf.ad),
        .o_busy  (rdiv_busy),
        .o_quot  (rq)
    );

    bti_div #(.NW(MW), .DW(MAG_W)) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({r_cf.an, {FRAC_BITS{1'b0}}}),
        .i_den   (r_cf.ad),
        .o_busy  (cdiv_busy),
        .o_quot  (cq)
    );

    // Operand selection for the shared linear step; a flat segment uses m = 0.
    always_comb begin
        unique case (i_cmd.lerp_sel)
            LERP_ZU: begin
                l_a   = r_g[2];
                l_b   = r_g[3];
                l_m   = r_cf.deg ? '0 : cq;
                l_neg = r_cf.neg;
            end
            LERP_ROW: begin
                l_a   = r_zl;
                l_b   = r_zu;
                l_m   = r_rf.deg ? '0 : rq;
                l_neg = r_rf.neg;
            end
            default: begin
                l_a   = r_g[0];
                l_b   = r_g[1];
                l_m   = r_cf.deg ? '0 : cq;
                l_neg = r_cf.neg;
            end
        endcase
    end

    bti_lerp #(.VW(VW), .MW(MW), .FB(FRAC_BITS), .VB(VALUE_BITS)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lerp_start),
        .i_a     (l_a),
        .i_b     (l_b),
        .i_m_mag (l_m),
        .i_m_neg (l_neg),
        .o_busy  (lerp_busy),
        .o_value (lerp_val)
    );

    assign o_stat.srch_done = r_rdone && r_cdone;
    assign o_stat.div_done  = !rdiv_busy && !cdiv_busy;
    assign o_stat.lerp_done = !lerp_busy;
    assign o_result         = r_result;
    assign o_status         = r_status;

endmodule
`default_nettype wire

// ----- sv/bti_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Interpolation controller
// Sequences search, segment fetch, division, grid reads, the three linear
// steps and the result handoff.
// ----------------------------------------------------------------------------
module bti_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire bti_pkg::t_opcode i_opcode,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output bti_pkg::t_cmd         o_cmd,
    input  wire bti_pkg::t_stat   i_stat
);
    import bti_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCMP, S_BLO, S_BHI, S_BCAP, S_PREP,
        S_GRID, S_DIVW, S_LST, S_LWT, S_OUT
    } t_state;

    t_state     r_state;
    logic [1:0] r_gk;
    logic [1:0] r_lk;
    logic       r_out_valid;
    logic       accept;
    t_cmd       cmd;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // Command decode from the current state.
    always_comb begin
        cmd        = '0;
        cmd.accept = accept;
        unique case (r_state)
            S_SCMP: cmd.srch_cmp = 1'b1;
            S_BLO:  cmd.brk_lo   = 1'b1;
            S_BHI:  cmd.cap_lo   = 1'b1;
            S_BCAP: cmd.cap_hi   = 1'b1;
            S_PREP: cmd.prep     = 1'b1;
            S_GRID: begin
                cmd.grid_rd   = 1'b1;
                cmd.grid_idx  = r_gk;
                cmd.div_start = (r_gk == 2'd0);
            end
            S_LST: begin
                cmd.lerp_start = 1'b1;
                cmd.lerp_sel   = r_lk;
            end
            S_LWT: begin
                cmd.lerp_sel = r_lk;
                cmd.lerp_cap = i_stat.lerp_done;
            end
            S_OUT:  cmd.out_load = !r_out_valid || !i_out_stall;
            default: cmd.accept  = accept;
        endcase
    end

    // State, counters and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gk        <= 2'd0;
            r_lk        <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result is loaded, or the held one is taken.
            if ((r_state == S_OUT) && cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == OP_QUERY)) begin
                        r_state <= S_SRD;
                    end
                end
                S_SRD:  r_state <= i_stat.srch_done ? S_BLO : S_SCMP;
                S_SCMP: r_state <= S_SRD;
                S_BLO:  r_state <= S_BHI;
                S_BHI:  r_state <= S_BCAP;
                S_BCAP: r_state <= S_PREP;
                S_PREP: begin
                    r_state <= S_GRID;
                    r_gk    <= 2'd0;
                end
                S_GRID: begin
                    r_gk <= r_gk + 2'd1;
                    if (r_gk == 2'd3) begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (i_stat.div_done) begin
                        r_state <= S_LST;
                        r_lk    <= LERP_ZL;
                    end
                end
                S_LST:  r_state <= S_LWT;
                S_LWT: begin
                    if (i_stat.lerp_done) begin
                        if (r_lk == LERP_ROW) begin
                            r_state <= S_OUT;
                        end else begin
                            r_lk    <= r_lk + 2'd1;
                            r_state <= S_LST;
                        end
                    end
                end
                S_OUT: begin
                    if (cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTHESIS
    // A query always starts the breakpoint search.
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_QUERY)) |=> (r_state == S_SRD))
        else $error("query did not start search");

    // Dividers are idle when a new division starts.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> i_stat.div_done)
        else $error("divider restarted while busy");

    // The linear step unit is idle when started.
    a_lerp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lerp_start |-> i_stat.lerp_done)
        else $error("linear step restarted while busy");

    // A finished result waits while the previous one is still held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result overwrote an untaken word");
`endif

endmodule
`default_nettype wire

// ----- sv/bilinear_table_interpolation_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear table interpolation unit
// Breakpoint and grid stores with a sequential bilinear query engine.
// ----------------------------------------------------------------------------
// Write words (row breakpoint, column breakpoint, grid value) are taken one
// per cycle while no query is in progress and produce no output. A query
// word finds the bracketing segment on both axes by walking the breakpoint
// tables with a read state and a compare state per entry, fetches the
// segment ends and four grid values, divides for both axis fractions on two
// bit-per-cycle dividers, and runs three linear steps on one chunked
// multiplier. The input stalls while a query runs, and one finished result
// may wait in the output register while the next word is accepted.
// Out-of-range queries extrapolate from the end segments. The stores come
// up unwritten and have no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_table_interpolation_unit #(
    parameter int MAX_ROWS   = bti_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = bti_pkg::DEF_MAX_COLS,
    parameter int VALUE_BITS = bti_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS  = bti_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [3:0]                        i_row_index,
    input  wire logic [3:0]                        i_col_index,
    input  wire logic signed [bti_pkg::WORD_W-1:0] i_write_value,
    input  wire logic signed [bti_pkg::WORD_W-1:0] i_query_row,
    input  wire logic signed [bti_pkg::WORD_W-1:0] i_query_col,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [bti_pkg::WORD_W-1:0]      o_result,
    output logic [1:0]                             o_status,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [bti_pkg::CFG_W-1:0]         i_cfg_data
);
    import bti_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_opcode opcode;
    t_status status;
    logic [WORD_W-1:0] result;

    assign opcode = t_opcode'(i_opcode);

    bti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bti_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (opcode),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .i_query_row   (i_query_row),
        .i_query_col   (i_query_col),
        .o_result      (result),
        .o_status      (status)
    );

    // Registers accept a write on any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_result    = $signed(result);
    assign o_status    = status;

endmodule
`default_nettype wire
